>>> rtl/core/fla_pkg.sv
package fla_pkg;

  // Pool geometry.
  localparam int unsigned POOL_SLOTS = 1024;
  localparam int unsigned SLOT_W     = $clog2(POOL_SLOTS);
  localparam int unsigned CNT_W      = $clog2(POOL_SLOTS + 1);

  // Fixed widths of the channel fields.
  localparam int unsigned SLOT_FIELD_W   = 10;
  localparam int unsigned STATUS_FIELD_W = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_FIELD_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/fla_req_if.sv
interface fla_req_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [fla_pkg::SLOT_FIELD_W-1:0]  slot_number;

  modport source (output valid, output operation, output slot_number, input ready);
  modport sink   (input valid, input operation, input slot_number, output ready);
endinterface

>>> rtl/core/fla_rsp_if.sv
interface fla_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [fla_pkg::SLOT_FIELD_W-1:0]   granted_slot;
  logic [fla_pkg::STATUS_FIELD_W-1:0] status;
  logic                               clear_entry;

  modport source (output valid, output granted_slot, output status, output clear_entry,
                  input ready);
  modport sink   (input valid, input granted_slot, input status, input clear_entry,
                  output ready);
endinterface

>>> rtl/core/fla_ctrl.sv
module fla_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fla_pkg::sts_t sts_i,
  output fla_pkg::cmd_t cmd_o
);

  fla_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fla_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a request is taken in idle, then executed once the
  // result register can take the answer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fla_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = fla_pkg::ST_EXEC;
      end
      fla_pkg::ST_EXEC: begin
        if (sts_i.out_free) state_d = fla_pkg::ST_IDLE;
      end
      default: state_d = fla_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      fla_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      fla_pkg::ST_EXEC: begin
        cmd_o.exec = sts_i.out_free;
      end
      default: ;
    endcase
  end

  // An accepted request is always followed by an execute state.
  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == fla_pkg::ST_EXEC)
    else $error("capture not followed by execute");

  // Execution never overwrites a result that is still waiting.
  a_exec_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> sts_i.out_free)
    else $error("execute while result register busy");

  // No new request is taken while one is executing.
  a_no_accept_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fla_pkg::ST_EXEC |-> !in_ready_o)
    else $error("ready raised during execute");

endmodule

>>> rtl/core/fla_datapath.sv
module fla_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fla_pkg::cmd_t                      cmd_i,
  output fla_pkg::sts_t                      sts_o,
  input  logic                               operation_i,
  input  logic [fla_pkg::SLOT_FIELD_W-1:0]   slot_number_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [fla_pkg::SLOT_FIELD_W-1:0]   granted_slot_o,
  output logic [fla_pkg::STATUS_FIELD_W-1:0] status_o,
  output logic                               clear_entry_o
);

  localparam int unsigned SlotW = fla_pkg::SLOT_W;
  localparam int unsigned CntW  = fla_pkg::CNT_W;

  // In-use bits and the stack of freed slots. Entries of the in-use memory
  // at or above the high-water mark are read but never used, so they need no clear.
  logic             in_use_mem [fla_pkg::POOL_SLOTS];
  logic [SlotW-1:0] stack_mem  [fla_pkg::POOL_SLOTS];

  logic [CntW-1:0]  freed_count_q, freed_count_d;
  logic [CntW-1:0]  high_water_q, high_water_d;
  logic             out_valid_q, out_valid_d;

  logic             op_q;
  logic [fla_pkg::SLOT_FIELD_W-1:0] slot_q;
  logic             in_use_rd_q;
  logic [SlotW-1:0] stack_rd_q;

  logic [fla_pkg::SLOT_FIELD_W-1:0]   granted_q, granted_d;
  fla_pkg::status_e                   status_q, status_d;
  logic                               clear_q, clear_d;

  logic             use_we, use_wdata, stack_we;
  logic [SlotW-1:0] use_waddr;
  logic [SlotW-1:0] got_slot;
  logic [CntW-1:0]  top_index;
  logic             free_in_range;

  assign top_index       = freed_count_q - CntW'(1);
  assign free_in_range   = 32'(slot_q) < 32'(high_water_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Capture the request and issue both memory reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q        <= operation_i;
      slot_q      <= slot_number_i;
      in_use_rd_q <= in_use_mem[SlotW'(slot_number_i)];
      stack_rd_q  <= stack_mem[top_index[SlotW-1:0]];
    end
  end

  // Execute: decide the result and the state updates.
  always_comb begin
    freed_count_d = freed_count_q;
    high_water_d  = high_water_q;
    use_we        = 1'b0;
    use_wdata     = 1'b0;
    use_waddr     = SlotW'(slot_q);
    stack_we      = 1'b0;
    got_slot      = '0;
    granted_d     = '0;
    status_d      = fla_pkg::STATUS_DONE;
    clear_d       = 1'b0;
    if (op_q == fla_pkg::OP_ALLOC) begin
      if (freed_count_q != '0) begin
        got_slot      = stack_rd_q;
        freed_count_d = top_index;
        use_we        = 1'b1;
      end else if (32'(high_water_q) < fla_pkg::POOL_SLOTS) begin
        got_slot      = high_water_q[SlotW-1:0];
        high_water_d  = high_water_q + CntW'(1);
        use_we        = 1'b1;
      end else begin
        status_d      = fla_pkg::STATUS_FULL;
      end
      use_wdata = 1'b1;
      use_waddr = got_slot;
      granted_d = fla_pkg::SLOT_FIELD_W'(got_slot);
    end else begin
      if (free_in_range && in_use_rd_q) begin
        use_we        = 1'b1;
        stack_we      = 1'b1;
        freed_count_d = freed_count_q + CntW'(1);
        clear_d       = 1'b1;
      end else begin
        status_d      = fla_pkg::STATUS_IGNORED;
      end
    end
  end

  // Memory writes happen only in the execute cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && use_we) begin
      in_use_mem[use_waddr] <= use_wdata;
    end
    if (cmd_i.exec && stack_we) begin
      stack_mem[freed_count_q[SlotW-1:0]] <= SlotW'(slot_q);
    end
  end

  // Counters and result valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freed_count_q <= '0;
      high_water_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.exec) begin
        freed_count_q <= freed_count_d;
        high_water_q  <= high_water_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      granted_q <= granted_d;
      status_q  <= status_d;
      clear_q   <= clear_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_slot_o = granted_q;
  assign status_o       = status_q;
  assign clear_entry_o  = clear_q;

  // Every freed slot was once handed out.
  a_count_le_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    freed_count_q <= high_water_q)
    else $error("freed count above high-water mark");

  // The high-water mark stays within the pool.
  a_hw_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(high_water_q) <= fla_pkg::POOL_SLOTS)
    else $error("high-water mark beyond pool");

  // A full answer only comes with an empty stack and an exhausted pool.
  a_full_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && status_d == fla_pkg::STATUS_FULL |->
      freed_count_q == '0 && 32'(high_water_q) == fla_pkg::POOL_SLOTS)
    else $error("full reported while slots remain");

endmodule

>>> rtl/core/free_list_index_allocator.sv
// Slot allocator for a pool of fla_pkg::POOL_SLOTS entries. Each request
// transfer (allocate, or free a given slot) yields exactly one result
// transfer: an allocate returns the most recently freed slot, or else the
// next fresh slot at the high-water mark, or reports the pool full; a free
// of a slot in use releases it and raises clear_entry, while a free of a
// slot that is out of range or already free is reported as ignored. A
// request is handled by a capture step, reading the in-use memory and the
// freed stack into registers, then an execute step that updates them and
// loads the result register once it is free. The next request is taken
// while a result still waits there. No clearing pass is needed after reset.
module free_list_index_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  fla_req_if.sink    req_i,
  fla_rsp_if.source  rsp_o
);

  fla_pkg::cmd_t cmd;
  fla_pkg::sts_t sts;

  fla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fla_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (req_i.operation),
    .slot_number_i  (req_i.slot_number),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .granted_slot_o (rsp_o.granted_slot),
    .status_o       (rsp_o.status),
    .clear_entry_o  (rsp_o.clear_entry)
  );

endmodule
